[hdl/fmmn_pkg.sv]
// Shared constants and controller/datapath interface types for the frame normalizer.
package fmmn_pkg;

   // Meaning of the one-bit word kind carried on tuser of the request channel.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_REQ  = 1'b1;

   // Width of the normalized result and number of divider iterations.
   localparam int QUOT_BITS = 16;
   localparam int STEP_W    = $clog2(QUOT_BITS);

   typedef struct packed {
      logic load;      // store a sample word
      logic start;     // latch a read request and read the frame store
      logic fetch;     // form the scaled numerator and seed the divider
      logic step;      // one restoring division step
      logic out_load;  // move the finished result into the output register
   } cmd_type;

   typedef struct packed {
      logic out_free;  // output register can take a result this cycle
   } sts_type;

endpackage

[hdl/fmmn_ctrl.sv]
// Controller state machine that sequences loads, reads and the divider.
module fmmn_ctrl
   import fmmn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_kind,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.load     = accept && (req_kind == KIND_LOAD);
      cmd.start    = accept && (req_kind == KIND_REQ);
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            step_in   = '0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QUOT_BITS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[hdl/fmmn_datapath.sv]
// Datapath: frame store, running min and max, serial divider and output register.
module fmmn_datapath
   import fmmn_pkg::*;
#(
   parameter int MAX_PIXELS  = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          last_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [QUOT_BITS-1:0]          rsp_norm,
   output logic                          rsp_last,
   output logic                          rsp_hit
);

   localparam int SB     = SAMPLE_BITS;
   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int ADDR_W = $clog2(MAX_PIXELS);
   localparam int NUM_W  = SB + QUOT_BITS;

   logic [SB-1:0] mem [MAX_PIXELS];

   logic [CNT_W-1:0]     count_ff, count_in, ridx_ff, eff_cnt, ridx_nxt;
   logic                 ready_ff, ready_in;
   logic signed [SB-1:0] min_ff, min_in, max_ff, max_in;
   logic [SB-1:0]        range_ff, range_in;
   logic [SB-1:0]        diff;
   logic                 room, first;
   logic [SB-1:0]        rd_data_ff;
   logic                 hit_ff, last_ff;
   logic [SB-1:0]        off_wide;
   logic [NUM_W-1:0]     numer;
   logic [SB-1:0]        rem_ff;
   logic [QUOT_BITS-1:0] low_ff, quo_ff;
   logic [SB:0]          trial;
   logic                 qbit;
   logic                 out_valid_ff;
   logic [QUOT_BITS-1:0] out_norm_ff;
   logic                 out_last_ff, out_hit_ff;

   // A load after a finished frame starts a fresh one.
   assign eff_cnt = ready_ff ? '0 : count_ff;
   assign room    = (eff_cnt != CNT_W'(MAX_PIXELS));
   assign first   = (eff_cnt == '0);

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (room) begin
         if (first || (sample < min_ff)) begin
            min_in = sample;
         end
         if (first || (sample > max_ff)) begin
            max_in = sample;
         end
      end
      // The range always fits in SB bits as an unsigned value.
      diff     = max_in - min_in;
      range_in = diff;
      count_in = room ? eff_cnt + CNT_W'(1) : eff_cnt;
      ready_in = last_sample;
   end

   assign ridx_nxt = ridx_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ridx_ff  <= '0;
         ready_ff <= 1'b0;
         min_ff   <= '0;
         max_ff   <= '0;
         range_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= count_in;
         ridx_ff  <= '0;
         ready_ff <= ready_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         if (last_sample) begin
            range_ff <= range_in;
         end
      end else if (cmd.start) begin
         if (ready_ff && (ridx_ff < count_ff)) begin
            ridx_ff <= ridx_nxt;
         end
      end
   end

   // Frame store: one write port for loads, one registered read port for requests.
   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         mem[eff_cnt[ADDR_W-1:0]] <= sample;
      end
      if (cmd.start) begin
         rd_data_ff <= mem[ridx_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hit_ff  <= ready_ff && (ridx_ff < count_ff);
         last_ff <= (ridx_nxt == count_ff);
      end
   end

   // Numerator is off * 65535, formed as (off << 16) - off. The offset lies in
   // 0..range, so it fits in SB bits as an unsigned value.
   assign off_wide = rd_data_ff - min_ff;
   assign numer    = {off_wide, {QUOT_BITS{1'b0}}}
                   - {{QUOT_BITS{1'b0}}, off_wide};
   assign trial    = {rem_ff, low_ff[QUOT_BITS-1]};
   assign qbit     = (trial >= {1'b0, range_ff});

   // Restoring division, one quotient bit per step. The upper numerator part is
   // below any nonzero range since the offset never exceeds it.
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rem_ff <= numer[NUM_W-1:QUOT_BITS];
         low_ff <= numer[QUOT_BITS-1:0];
         quo_ff <= '0;
      end else if (cmd.step) begin
         rem_ff <= qbit ? SB'(trial - {1'b0, range_ff}) : trial[SB-1:0];
         low_ff <= {low_ff[QUOT_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[QUOT_BITS-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_norm_ff <= (hit_ff && (range_ff != '0)) ? quo_ff : '0;
         out_last_ff <= hit_ff && last_ff;
         out_hit_ff  <= hit_ff;
      end
   end

   assign sts.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid    = out_valid_ff;
   assign rsp_norm     = out_norm_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_hit      = out_hit_ff;

endmodule

[hdl/frame_min_max_normalizer.sv]
// Frame min-max normalizer: loads a frame of samples and streams them out scaled to 0..65535.
//
// Request channel (req_): each word either loads a sample (tuser kind = 0) or
// asks for the next normalized sample (tuser kind = 1). A load with tlast set
// closes the frame; its range max - min is latched and the frame becomes ready.
// A load after a ready frame discards it and starts a new one. Samples beyond
// MAX_PIXELS are dropped, though their tlast still closes the frame.
// Response channel (rsp_): one word per read request, none per load. tdata is
// floor((p - min) * 65535 / range), tlast marks the final sample of the frame
// and tuser says whether a sample was available; a zero range gives 0.
// Throughput: a load is taken every cycle while no read request is in progress.
// A read request passes the controller's store read, numerator, 16 steps of the
// one-bit-per-cycle restoring divider and hand-off; the result appears in the
// output register the cycle after the hand-off and req_tready returns at the same time.
// If the receiver stalls, the result waits in the output register while loads
// and one further request proceed; that request then waits in the hand-off state.
// Reset is synchronous and clears the frame, so requests right after reset
// answer with tuser 0. The frame store itself is not cleared.
module frame_min_max_normalizer
   import fmmn_pkg::*;
#(
   parameter int MAX_PIXELS  = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // sample_value
   input  logic                                   req_tlast,  // last_sample
   input  logic [0:0]                             req_tuser,  // kind
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [QUOT_BITS-1:0]                   rsp_tdata,  // norm_value
   output logic                                   rsp_tlast,  // last_out
   output logic [0:0]                             rsp_tuser   // valid_out
);

   cmd_type cmd;
   sts_type sts;

   fmmn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser[0]),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fmmn_datapath #(
      .MAX_PIXELS  (MAX_PIXELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .sample      ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .last_sample (req_tlast),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_norm    (rsp_tdata),
      .rsp_last    (rsp_tlast),
      .rsp_hit     (rsp_tuser[0])
   );

endmodule

[hdl/fmmn_checker.sv]
// Port-level assertions for the frame normalizer and the bind that attaches them.
module fmmn_checker
   import fmmn_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [0:0]           req_tuser,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [QUOT_BITS-1:0] rsp_tdata,
   input logic                 rsp_tlast,
   input logic [0:0]           rsp_tuser
);

   // A stalled result word keeps its data and its last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response word changed");

   // A miss carries neither data nor a frame end.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == 1'b0) |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("response without sample carries data or last");

   // An accepted read request occupies the block on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == KIND_REQ) |=> !req_tready)
      else $error("request channel ready right after a read request");

   // Nothing is presented on the first cycle after reset is released.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind frame_min_max_normalizer fmmn_checker u_fmmn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
